### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framing deframer checkers
// Clocked concurrent assertions that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SEFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sefd assertion failed");

// Next-cycle implication.
`define SEFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sefd assertion failed");

`endif

### rtl/sefd_pkg.sv
// ----------------------------------------------------------------------------
// sefd_pkg
// Shared types and constants of the STX/ETX frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sefd_pkg;

  // Default sizing of the top level.
  localparam int MaxFrameLenDefault = 1024;
  localparam int MaxFieldsDefault   = 64;

  // Configuration port.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic [7:0] ReceiveIdReset = 8'h48;

  // Result kinds.
  localparam logic [2:0] KIND_DATA      = 3'd0;
  localparam logic [2:0] KIND_FIELD_END = 3'd1;
  localparam logic [2:0] KIND_GOOD      = 3'd2;
  localparam logic [2:0] KIND_WRONG_ID  = 3'd3;
  localparam logic [2:0] KIND_SHORT     = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] command;
    logic [5:0]  field_index;
  } result_t;

endpackage

`default_nettype wire

### rtl/sefd_byte_if.sv
// ----------------------------------------------------------------------------
// sefd_byte_if
// Valid/ready channel that carries one received byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sefd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/sefd_result_if.sv
// ----------------------------------------------------------------------------
// sefd_result_if
// Valid/ready channel that carries one deframer result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sefd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] command;
  logic [5:0]  field_index;

  modport source (output valid, output kind, output data_byte, output command,
                  output field_index, input ready);
  modport sink   (input valid, input kind, input data_byte, input command,
                  input field_index, output ready);
endinterface

`default_nettype wire

### rtl/sefd_cfg_regs.sv
// ----------------------------------------------------------------------------
// sefd_cfg_regs
// APB register file holding the expected sender id byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sefd_cfg_regs
  import sefd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [7:0]          receive_id_o
);

  logic [7:0] receive_id_q, receive_id_d;
  logic       sel_id;

  // Register index is the word address; only index zero exists.
  assign sel_id = (paddr[ApbAddrW-1:2] == '0);
  assign pready = 1'b1;

  always_comb begin
    receive_id_d = receive_id_q;
    if (psel && penable && pwrite && sel_id) begin
      receive_id_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receive_id_q <= ReceiveIdReset;
    end else begin
      receive_id_q <= receive_id_d;
    end
  end

  assign prdata       = sel_id ? {{(ApbDataW-8){1'b0}}, receive_id_q} : '0;
  assign receive_id_o = receive_id_q;

endmodule

`default_nettype wire

### rtl/sefd_parser.sv
// ----------------------------------------------------------------------------
// sefd_parser
// Frame state and the single-pass decision for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sefd_parser
  import sefd_pkg::*;
#(
  parameter int MAX_FRAME_LEN = MaxFrameLenDefault,
  parameter int MAX_FIELDS    = MaxFieldsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] receive_id_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int PosW     = $clog2(MAX_FRAME_LEN + 1);
  localparam int FieldTop = (MAX_FIELDS > 64) ? 63 : MAX_FIELDS - 1;

  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  logic            in_frame_q, in_frame_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     cmd_q, cmd_d;
  logic            hex_stop_q, hex_stop_d;
  logic            id_match_q, id_match_d;
  logic [5:0]      field_q, field_d;
  logic            id_match_eff;
  logic [4:0]      hex;

  assign hex = hex_decode(rx_byte_i);

  always_comb begin
    in_frame_d   = in_frame_q;
    pos_d        = pos_q;
    cmd_d        = cmd_q;
    hex_stop_d   = hex_stop_q;
    id_match_d   = id_match_q;
    field_d      = field_q;
    res_valid_o  = 1'b0;
    res_o        = '{kind: KIND_DATA, data_byte: 8'h00, command: cmd_q,
                     field_index: field_q};
    id_match_eff = (pos_q == PosW'(1)) ? (rx_byte_i == receive_id_i) : id_match_q;

    priority if (rx_byte_i == CH_STX) begin
      // A start byte always opens a fresh frame.
      in_frame_d = 1'b1;
      pos_d      = PosW'(1);
      cmd_d      = '0;
      hex_stop_d = 1'b0;
      id_match_d = 1'b0;
      field_d    = '0;
    end else if (in_frame_q) begin
      if (pos_q < PosW'(MAX_FRAME_LEN)) begin
        pos_d = pos_q + PosW'(1);
      end
      id_match_d = id_match_eff;
      priority if (rx_byte_i == CH_ETX) begin
        // Wrong id takes precedence; a frame of fewer than seven bytes is short.
        in_frame_d  = 1'b0;
        res_valid_o = 1'b1;
        if (!id_match_eff) begin
          res_o.kind = KIND_WRONG_ID;
        end else if (pos_q < PosW'(6)) begin
          res_o.kind = KIND_SHORT;
        end else begin
          res_o.kind = KIND_GOOD;
        end
      end else if (pos_q == PosW'(1)) begin
        res_valid_o = 1'b0;
      end else if (pos_q >= PosW'(2) && pos_q <= PosW'(5)) begin
        if (!hex_stop_q) begin
          if (hex[4]) begin
            cmd_d = {cmd_q[11:0], hex[3:0]};
          end else begin
            hex_stop_d = 1'b1;
          end
        end
      end else if (id_match_q) begin
        res_valid_o = 1'b1;
        if (rx_byte_i == CH_COMMA) begin
          res_o.kind = KIND_FIELD_END;
          if (field_q < 6'(FieldTop)) begin
            field_d = field_q + 6'd1;
          end
        end else begin
          res_o.data_byte = rx_byte_i;
        end
      end else begin
        res_valid_o = 1'b0;
      end
    end else begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      cmd_q      <= '0;
      hex_stop_q <= 1'b0;
      id_match_q <= 1'b0;
      field_q    <= '0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      cmd_q      <= cmd_d;
      hex_stop_q <= hex_stop_d;
      id_match_q <= id_match_d;
      field_q    <= field_d;
    end
  end

endmodule

`default_nettype wire

### rtl/stx_etx_frame_deframer_unit.sv
// An accepted byte waits in the input register; the parser decides on it
// combinationally; the result register takes it when empty or drained.
// Throughput: one byte per cycle, limited by the single parser pass between
// the input register and the result register; output stalls backpressure.
// Reset (rst_ni, asynchronous, active low) leaves the block outside any frame,
// with both registers empty and the receive id set to 'H'.
// ----------------------------------------------------------------------------
// stx_etx_frame_deframer_unit
// Recovers STX/ETX framed commands and data fields from a byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_etx_frame_deframer_unit
  import sefd_pkg::*;
#(
  parameter int MAX_FRAME_LEN = MaxFrameLenDefault,
  parameter int MAX_FIELDS    = MaxFieldsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sefd_byte_if.sink           in_if,
  sefd_result_if.source       out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_res_q;
  logic       advance;
  logic       step;
  logic       in_ready;
  logic [7:0] receive_id;
  logic       res_valid;
  result_t    res;

  sefd_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .receive_id_o (receive_id)
  );

  sefd_parser #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN),
    .MAX_FIELDS    (MAX_FIELDS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .rx_byte_i    (in_byte_q),
    .receive_id_i (receive_id),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // The result register moves whenever it is empty or being drained.
  assign advance  = !out_valid_q || out_if.ready;
  assign step     = in_valid_q && advance;
  assign in_ready = !in_valid_q || advance;

  assign in_if.ready = in_ready;

  always_comb begin
    in_valid_d  = in_ready ? in_if.valid : in_valid_q;
    out_valid_d = advance ? (step && res_valid) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_if.valid) begin
      in_byte_q <= in_if.rx_byte;
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.kind        = out_res_q.kind;
  assign out_if.data_byte   = out_res_q.data_byte;
  assign out_if.command     = out_res_q.command;
  assign out_if.field_index = out_res_q.field_index;

endmodule

`default_nettype wire

### rtl/sefd_checker.sv
// ----------------------------------------------------------------------------
// sefd_checker
// Port-level checks of the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sefd_checker
  import sefd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_kind_i,
  input logic [7:0]  out_data_byte_i,
  input logic [15:0] out_command_i,
  input logic [5:0]  out_field_index_i
);

  logic        stalled;
  logic        not_data;
  logic        kind_known;
  logic [32:0] payload;

  assign stalled    = out_valid_i && !out_ready_i;
  assign not_data   = out_valid_i && (out_kind_i != KIND_DATA);
  assign payload    = {out_kind_i, out_data_byte_i, out_command_i, out_field_index_i};
  assign kind_known = (out_kind_i == KIND_DATA) || (out_kind_i == KIND_FIELD_END) ||
                      (out_kind_i == KIND_GOOD) || (out_kind_i == KIND_WRONG_ID) ||
                      (out_kind_i == KIND_SHORT);

  // A stalled result keeps its valid and its payload.
  `SEFD_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, stalled, out_valid_i)
  `SEFD_ASSERT_NEXT(a_payload_hold, clk_i, rst_ni, stalled, $stable(payload))

  // Only data results carry a payload byte.
  `SEFD_ASSERT_IMP(a_data_zero, clk_i, rst_ni, not_data, out_data_byte_i == 8'h00)

  // The result kind stays within the defined codes.
  `SEFD_ASSERT_IMP(a_kind_range, clk_i, rst_ni, out_valid_i, kind_known)

endmodule

bind stx_etx_frame_deframer_unit sefd_checker u_sefd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .out_kind_i        (out_if.kind),
  .out_data_byte_i   (out_if.data_byte),
  .out_command_i     (out_if.command),
  .out_field_index_i (out_if.field_index)
);

`default_nettype wire
